// ===== rtl/kvm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the key velocity MIDI scanner.
// Depends on nothing; every module file imports it.
package kvm_pkg;

  localparam int KEY_BITS = 4;
  localparam int VAL_BITS = 7;
  localparam int CHAN_BITS = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 7;
  localparam int NOTE_SUM_BITS = 12;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [7:0] STATUS_ON = 8'h90;
  localparam logic [7:0] STATUS_OFF = 8'h80;
  localparam logic [VAL_BITS-1:0] NOTE_MAX = 7'd127;

  localparam logic [CFG_IDX_BITS-1:0] REG_NOTE_BASE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NOTE_STEP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEL_TOP = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEL_SLOPE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL = 3'd4;

  localparam logic [VAL_BITS-1:0] RST_NOTE_BASE = 7'd60;
  localparam logic [VAL_BITS-1:0] RST_NOTE_STEP = 7'd2;
  localparam logic [VAL_BITS-1:0] RST_VEL_TOP = 7'd120;
  localparam logic [VAL_BITS-1:0] RST_VEL_SLOPE = 7'd6;
  localparam logic [CHAN_BITS-1:0] RST_CHANNEL = 4'd0;

  typedef struct packed {
    logic [VAL_BITS-1:0] note_base;
    logic [VAL_BITS-1:0] note_step;
    logic [VAL_BITS-1:0] velocity_top;
    logic [VAL_BITS-1:0] velocity_slope;
    logic [CHAN_BITS-1:0] midi_channel;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status;
    logic [VAL_BITS-1:0] note;
    logic [VAL_BITS-1:0] velocity;
  } msg_t;

  typedef struct packed {
    logic valid;
    msg_t msg;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
    msg_t msg;
  } qstat_t;

endpackage

// ===== rtl/kvm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for key samples and MIDI bytes.
// Depends on nothing beyond the language itself.
interface kvm_sample_if;
  logic valid;
  logic ready;
  logic action;
  logic [3:0] key_number;
  logic first_contact;
  logic second_contact;

  modport source(output valid, action, key_number, first_contact, second_contact,
                 input ready);
  modport sink(input valid, action, key_number, first_contact, second_contact,
               output ready);
endinterface

interface kvm_midi_if;
  logic valid;
  logic ready;
  logic [7:0] midi_byte;
  logic last_byte;

  modport source(output valid, midi_byte, last_byte, input ready);
  modport sink(input valid, midi_byte, last_byte, output ready);
endinterface

// ===== rtl/kvm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples and ticks, keeps per-key contact state and
// builds note-on and note-off messages. Depends on kvm_pkg and kvm_if.
module kvm_front #(
  parameter int NUM_KEYS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  kvm_sample_if.sink samples,
  input  kvm_pkg::cfg_t cfg,
  input  kvm_pkg::qstat_t qstat,
  output kvm_pkg::push_t push
);
  import kvm_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int DROP_BITS = TIME_BITS + VAL_BITS;

  logic [TIME_BITS-1:0] start_mem [NUM_KEYS];
  logic [TIME_BITS-1:0] start_rd;
  logic [TIME_BITS-1:0] byp_data;
  logic byp_hit;

  logic [NUM_KEYS-1:0] armed;
  logic [NUM_KEYS-1:0] sent;
  logic [TIME_BITS-1:0] time_count;

  logic s2_valid;
  logic s2_action;
  logic [KEY_BITS-1:0] s2_key;
  logic s2_first;
  logic s2_second;
  logic s2_in_range;

  logic accept;
  logic s2_fire;
  logic s2_sample;
  logic [KW-1:0] in_idx;
  logic [KW-1:0] s2_idx;
  logic in_range;
  logic armed_cur;
  logic sent_cur;
  logic start_wr;
  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic [DROP_BITS-1:0] drop;
  logic [VAL_BITS-1:0] vel;
  logic [NOTE_SUM_BITS-1:0] note_sum;
  logic [VAL_BITS-1:0] note;
  logic send_on;
  logic send_off;

  assign samples.ready = !s2_valid || !qstat.full;
  assign accept = samples.valid && samples.ready;
  assign s2_fire = s2_valid && !qstat.full;
  assign s2_sample = s2_fire && (s2_action == ACT_SAMPLE) && s2_in_range;

  assign in_idx = KW'(samples.key_number);
  assign s2_idx = KW'(s2_key);
  assign in_range = int'(samples.key_number) < NUM_KEYS;

  assign armed_cur = armed[s2_idx];
  assign sent_cur = sent[s2_idx];
  assign start_wr = s2_sample && s2_first && armed_cur;

  always_comb begin
    if (s2_first && armed_cur) begin
      start_eff = time_count;
    end else if (byp_hit) begin
      start_eff = byp_data;
    end else begin
      start_eff = start_rd;
    end
  end

  assign elapsed = time_count - start_eff;
  assign drop = DROP_BITS'(elapsed) * DROP_BITS'(cfg.velocity_slope);
  assign vel = (drop >= DROP_BITS'(cfg.velocity_top)) ? '0
             : cfg.velocity_top - drop[VAL_BITS-1:0];

  assign note_sum = NOTE_SUM_BITS'(cfg.note_base)
                  + NOTE_SUM_BITS'(s2_key) * NOTE_SUM_BITS'(cfg.note_step);
  assign note = (note_sum > NOTE_SUM_BITS'(NOTE_MAX)) ? NOTE_MAX : note_sum[VAL_BITS-1:0];

  assign send_off = s2_sample && !s2_second && sent_cur;
  assign send_on = s2_sample && s2_second && s2_first && !sent_cur;

  always_comb begin
    push.valid = send_on || send_off;
    push.msg.status = (s2_second ? STATUS_ON : STATUS_OFF) | {4'b0, cfg.midi_channel};
    push.msg.note = note;
    push.msg.velocity = s2_second ? vel : '0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_rd <= start_mem[in_idx];
      byp_hit <= start_wr && (s2_idx == in_idx);
      byp_data <= time_count;
    end
    if (start_wr) begin
      start_mem[s2_idx] <= time_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_action <= samples.action;
      s2_key <= samples.key_number;
      s2_first <= samples.first_contact;
      s2_second <= samples.second_contact;
      s2_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      time_count <= '0;
      armed <= '1;
      sent <= '0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (s2_fire && (s2_action == ACT_TICK)) begin
        time_count <= time_count + 1'b1;
      end
      if (s2_sample) begin
        armed[s2_idx] <= !s2_first || s2_second;
      end
      if (send_on) begin
        sent[s2_idx] <= 1'b1;
      end else if (send_off) begin
        sent[s2_idx] <= 1'b0;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push.valid)
    else $error("message offered to a full queue");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s2_valid && qstat.full |=> s2_valid)
    else $error("stalled item lost");

  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    s2_valid && (s2_action == ACT_TICK) |-> !push.valid)
    else $error("tick produced a message");

endmodule

// ===== rtl/kvm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry message queue between the front end and the byte serialiser.
// Depends on kvm_pkg.
module kvm_queue (
  input  logic clk,
  input  logic rst,
  input  kvm_pkg::push_t push,
  input  logic pop,
  output kvm_pkg::qstat_t qstat
);
  import kvm_pkg::*;

  msg_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign do_push = push.valid && (count != 2'd2);
  assign do_pop = pop && (count != 2'd0);

  always_comb begin
    qstat.valid = count != 2'd0;
    qstat.full = count == 2'd2;
    qstat.msg = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.msg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/kvm_back.sv =====
`timescale 1ns / 1ps
// Back end: holds one message and sends its three bytes, one per transfer.
// Depends on kvm_pkg and kvm_if.
module kvm_back (
  input  logic clk,
  input  logic rst,
  input  kvm_pkg::qstat_t qstat,
  output logic pop,
  kvm_midi_if.source midi
);
  import kvm_pkg::*;

  localparam logic [1:0] BYTE_STATUS = 2'd0;
  localparam logic [1:0] BYTE_NOTE = 2'd1;
  localparam logic [1:0] BYTE_VEL = 2'd2;

  msg_t cur;
  logic busy;
  logic [1:0] idx;
  logic xfer;
  logic done;

  assign xfer = midi.valid && midi.ready;
  assign done = xfer && (idx == BYTE_VEL);
  assign pop = qstat.valid && (!busy || done);

  assign midi.valid = busy;
  assign midi.last_byte = idx == BYTE_VEL;

  always_comb begin
    case (idx)
      BYTE_STATUS: midi.midi_byte = cur.status;
      BYTE_NOTE: midi.midi_byte = {1'b0, cur.note};
      BYTE_VEL: midi.midi_byte = {1'b0, cur.velocity};
      default: midi.midi_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= qstat.msg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= BYTE_STATUS;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= BYTE_STATUS;
    end else if (done) begin
      busy <= 1'b0;
      idx <= BYTE_STATUS;
    end else if (xfer) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== rtl/key_velocity_midi_scanner.sv =====
`timescale 1ns / 1ps
// Key velocity scanner: one sample or tick is taken per cycle while the front end is
// not stalled by a full queue; a message passes the front-end stage register, the
// queue and the back-end message register before its first byte is offered. Each
// message occupies the output for three byte transfers; the serialiser sets the rate.
// Reset is synchronous: registers return to defaults, keys armed and silent;
// the start-time memory is not cleared, as it is always written before use.
module key_velocity_midi_scanner #(
  parameter int NUM_KEYS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  kvm_sample_if.sink samples,
  kvm_midi_if.source midi,
  input  logic cfg_write,
  input  logic [kvm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [kvm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import kvm_pkg::*;

  cfg_t cfg;
  push_t push;
  qstat_t qstat;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.note_base <= RST_NOTE_BASE;
      cfg.note_step <= RST_NOTE_STEP;
      cfg.velocity_top <= RST_VEL_TOP;
      cfg.velocity_slope <= RST_VEL_SLOPE;
      cfg.midi_channel <= RST_CHANNEL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NOTE_BASE: cfg.note_base <= cfg_data;
        REG_NOTE_STEP: cfg.note_step <= cfg_data;
        REG_VEL_TOP: cfg.velocity_top <= cfg_data;
        REG_VEL_SLOPE: cfg.velocity_slope <= cfg_data;
        REG_CHANNEL: cfg.midi_channel <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  kvm_front #(
    .NUM_KEYS(NUM_KEYS),
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .cfg(cfg),
    .qstat(qstat),
    .push(push)
  );

  kvm_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .pop(pop),
    .qstat(qstat)
  );

  kvm_back u_back (
    .clk(clk),
    .rst(rst),
    .qstat(qstat),
    .pop(pop),
    .midi(midi)
  );

endmodule
